### hw/rtl/fcpt_pkg.sv
// Shared types and codes for the FIFO handle cache with pending tracking.
// No dependencies; imported by every module of the block.
package fcpt_pkg;

	localparam int TAG_W    = 64;
	localparam int HANDLE_W = 64;
	localparam int LIMIT_W  = 7;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 64;

	typedef enum logic [OP_W-1:0] {
		OP_REQUEST  = 2'd0,
		OP_COMPLETE = 2'd1,
		OP_FIND     = 2'd2,
		OP_CLEAR    = 2'd3
	} fcpt_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT       = 3'd0,
		STAT_QUEUED    = 3'd1,
		STAT_ALREADY   = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_DONE      = 3'd5
	} fcpt_status_t;

	typedef enum logic {
		REG_ENTRY_LIMIT = 1'b0,
		REG_FALLBACK    = 1'b1
	} fcpt_reg_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_UPD
	} fcpt_state_t;

	// per-cycle control for one store cell
	typedef struct packed {
		logic valid;   // cell lies inside the occupied window
		logic shift;   // take neighbour's entry (oldest evicted)
		logic load;    // take the inserted entry
	} fcpt_store_ctl_t;

	// per-cycle control for one pending cell
	typedef struct packed {
		logic set;
		logic clr;
	} fcpt_pend_ctl_t;

endpackage

### hw/rtl/fifo_cache_with_pending_tracking.sv
// FIFO handle cache with in-flight miss tracking: top level.
// Depends on fcpt_pkg, fcpt_store_cell and fcpt_pend_cell.
//
// Keyed cache of 64-bit handles held as a chain of CAPACITY cells in age
// order: cell 0 holds the oldest entry and an eviction moves every entry one
// cell down, so no ring pointer exists. Beside it sits a row of MAX_INFLIGHT
// pending cells recording keys whose misses are in flight. A request passes
// a compare step and an update step: in the compare step every cell compares
// its tag with the key and registers the result, in the update step the hit
// vectors are combined, the result is written to the output register and the
// chains are updated. A new request is taken in the update step, so with the
// output side ready the block can take a request while finishing the last
// one; the result appears in the cycle after the update. The output
// register lets the next request enter while a result waits; the update
// stalls only when a result is still unclaimed. The store needs no clearing
// after reset: cells outside the occupied window never hit. entry_limit
// above CAPACITY acts as CAPACITY, and a limit of zero acts as one.
module fifo_cache_with_pending_tracking import fcpt_pkg::*; #(
	parameter int CAPACITY     = 64,
	parameter int MAX_INFLIGHT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [TAG_W-1:0]    key_tag,
	input  logic [HANDLE_W-1:0] new_handle,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                evicted
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// configuration
	logic [LIMIT_W-1:0]  limit_q;
	logic [HANDLE_W-1:0] fallback_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_W'(64);
			fallback_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_FALLBACK:    fallback_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// control
	fcpt_state_t state_q, state_d;
	logic        accept;
	logic        out_free;
	logic        commit;   // update cycle that writes the result

	// request held through compare and update
	fcpt_op_t            op_s1;
	logic [TAG_W-1:0]    key_s1;
	logic [HANDLE_W-1:0] handle_s1;

	// occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_after_ev;
	logic [CNT_W-1:0] count_d;

	// cell vectors
	logic [TAG_W-1:0]    st_tag    [CAPACITY];
	logic [HANDLE_W-1:0] st_handle [CAPACITY];
	logic [CAPACITY-1:0] st_hit;
	fcpt_store_ctl_t     st_ctl    [CAPACITY];

	logic [MAX_INFLIGHT-1:0] pd_valid;
	logic [MAX_INFLIGHT-1:0] pd_hit_key;
	logic [MAX_INFLIGHT-1:0] pd_hit_old;
	logic [MAX_INFLIGHT-1:0] pd_free_1h;
	fcpt_pend_ctl_t          pd_ctl    [MAX_INFLIGHT];

	// decision terms for the update cycle
	logic                is_req, is_cmp, is_find, is_clr;
	logic                hit_any;
	logic [HANDLE_W-1:0] hit_handle;
	logic                do_evict;
	logic                present;
	logic                do_insert;
	logic                pd_full;
	logic                pd_dup;
	logic                do_queue;
	fcpt_status_t        status_d;
	logic [HANDLE_W-1:0] handle_d;

	// output register
	logic                out_valid_q;
	fcpt_status_t        status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic                evicted_q;

	assign out_free = !out_valid_q || out_ready;
	assign commit   = (state_q == FSM_UPD) && out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = FSM_CMP;
			end
			FSM_CMP: begin
				state_d = FSM_UPD;
			end
			FSM_UPD: begin
				in_ready = out_free;
				if (out_free) state_d = in_valid ? FSM_CMP : FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= fcpt_op_t'(operation);
			key_s1    <= key_tag;
			handle_s1 <= new_handle;
		end
	end

	assign is_req  = (op_s1 == OP_REQUEST);
	assign is_cmp  = (op_s1 == OP_COMPLETE);
	assign is_find = (op_s1 == OP_FIND);
	assign is_clr  = (op_s1 == OP_CLEAR);

	// hit combine: keys in the store are unique, so at most one cell hits
	always_comb begin
		hit_handle = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_handle = hit_handle | (st_handle[i] & {HANDLE_W{st_hit[i]}});
		end
	end
	assign hit_any = |st_hit;

	// eviction on a completion: count reached the clamped limit and store not empty
	assign do_evict = is_cmp && (count_q != '0) &&
		((CMP_W'(count_q) >= CMP_W'(limit_q)) || (count_q == CNT_W'(CAPACITY)));
	assign count_after_ev = count_q - CNT_W'(do_evict);

	// after eviction the oldest cell no longer counts as a hit
	assign present   = |(st_hit & ~(CAPACITY'(do_evict)));
	assign do_insert = is_cmp && !present && (count_after_ev < CNT_W'(CAPACITY));

	always_comb begin
		count_d = count_q;
		if (is_clr) begin
			count_d = '0;
		end else if (is_cmp) begin
			count_d = count_after_ev + CNT_W'(do_insert);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_d;
		end
	end

	// store chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_store
		logic [TAG_W-1:0]    nb_tag;
		logic [HANDLE_W-1:0] nb_handle;

		if (i + 1 < CAPACITY) begin : g_nb
			assign nb_tag    = st_tag[i+1];
			assign nb_handle = st_handle[i+1];
		end else begin : g_end
			assign nb_tag    = st_tag[i];
			assign nb_handle = st_handle[i];
		end

		assign st_ctl[i].valid = (CNT_W'(i) < count_q);
		assign st_ctl[i].shift = commit && do_evict;
		assign st_ctl[i].load  = commit && do_insert && (count_after_ev == CNT_W'(i));

		fcpt_store_cell u_cell (
			.clk       (clk),
			.ctl       (st_ctl[i]),
			.key       (key_s1),
			.nb_tag    (nb_tag),
			.nb_handle (nb_handle),
			.ld_tag    (key_s1),
			.ld_handle (handle_s1),
			.tag       (st_tag[i]),
			.handle    (st_handle[i]),
			.hit       (st_hit[i])
		);
	end

	// pending row: any free slot will do, take the lowest
	assign pd_free_1h = ~pd_valid & (pd_valid + MAX_INFLIGHT'(1));
	assign pd_full    = &pd_valid;
	assign pd_dup     = |pd_hit_key;
	assign do_queue   = is_req && !hit_any && !pd_full && !pd_dup;

	for (genvar j = 0; j < MAX_INFLIGHT; j++) begin : g_pend
		assign pd_ctl[j].set = commit && do_queue && pd_free_1h[j];
		assign pd_ctl[j].clr = commit && is_cmp &&
			(pd_hit_key[j] || (do_evict && pd_hit_old[j]));

		fcpt_pend_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (pd_ctl[j]),
			.key     (key_s1),
			.old_tag (st_tag[0]),
			.valid   (pd_valid[j]),
			.hit_key (pd_hit_key[j]),
			.hit_old (pd_hit_old[j])
		);
	end

	// result
	always_comb begin
		status_d = STAT_DONE;
		handle_d = '0;
		if (is_req || is_find) begin
			if (hit_any) begin
				status_d = STAT_HIT;
				handle_d = hit_handle;
			end else if (is_find) begin
				status_d = STAT_NOT_FOUND;
			end else begin
				handle_d = fallback_q;
				if (pd_full) begin
					status_d = STAT_FULL;
				end else if (pd_dup) begin
					status_d = STAT_ALREADY;
				end else begin
					status_d = STAT_QUEUED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			out_handle_q <= handle_d;
			evicted_q    <= do_evict;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_handle = out_handle_q;
	assign evicted    = evicted_q;

endmodule

### hw/rtl/fcpt_store_cell.sv
// One entry of the cache chain: tag, handle and a registered tag compare.
// Depends on fcpt_pkg.
module fcpt_store_cell import fcpt_pkg::*; (
	input  logic                clk,
	input  fcpt_store_ctl_t     ctl,
	input  logic [TAG_W-1:0]    key,
	input  logic [TAG_W-1:0]    nb_tag,
	input  logic [HANDLE_W-1:0] nb_handle,
	input  logic [TAG_W-1:0]    ld_tag,
	input  logic [HANDLE_W-1:0] ld_handle,
	output logic [TAG_W-1:0]    tag,
	output logic [HANDLE_W-1:0] handle,
	output logic                hit
);

	logic [TAG_W-1:0]    tag_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tag_q    <= ld_tag;
			handle_q <= ld_handle;
		end else if (ctl.shift) begin
			tag_q    <= nb_tag;
			handle_q <= nb_handle;
		end
		hit_q <= ctl.valid && (tag_q == key);
	end

	assign tag    = tag_q;
	assign handle = handle_q;
	assign hit    = hit_q;

endmodule

### hw/rtl/fcpt_pend_cell.sv
// One slot of the in-flight miss set: valid flag, tag and two registered compares.
// Depends on fcpt_pkg.
module fcpt_pend_cell import fcpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fcpt_pend_ctl_t   ctl,
	input  logic [TAG_W-1:0] key,
	input  logic [TAG_W-1:0] old_tag,
	output logic             valid,
	output logic             hit_key,
	output logic             hit_old
);

	logic             valid_q;
	logic [TAG_W-1:0] tag_q;
	logic             hit_key_q;
	logic             hit_old_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.set) begin
			valid_q <= 1'b1;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.set) begin
			tag_q <= key;
		end
		hit_key_q <= valid_q && (tag_q == key);
		hit_old_q <= valid_q && (tag_q == old_tag);
	end

	assign valid   = valid_q;
	assign hit_key = hit_key_q;
	assign hit_old = hit_old_q;

endmodule

### hw/rtl/fcpt_checker.sv
// Port-level checks for the FIFO handle cache, and the bind that attaches them.
// Depends on fcpt_pkg and fifo_cache_with_pending_tracking.
module fcpt_port_checks import fcpt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [HANDLE_W-1:0] out_handle,
	input logic                evicted
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_handle))
		else $error("result changed while stalled");

	// an eviction is reported only with a done result (completion or clear)
	a_evict_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> status == STAT_DONE)
		else $error("eviction reported on a non-completion");

	// miss on find and every done result carry a zero handle
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_NOT_FOUND || status == STAT_DONE) |-> out_handle == '0)
		else $error("non-zero handle on find miss or done");

	// the compare cycle after a taken request never takes another
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during compare");

endmodule

bind fifo_cache_with_pending_tracking fcpt_port_checks u_fcpt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.out_handle (out_handle),
	.evicted    (evicted)
);
